@@ src/cau_pkg.sv @@
// cau_pkg: operation codes and control types shared by the complex arithmetic unit
// no dependencies; compile first

package cau_pkg;

	localparam int FUNC_BITS = 3;

	typedef enum logic [FUNC_BITS-1:0] {
		FN_ADD = 3'd0,
		FN_SUB = 3'd1,
		FN_MUL = 3'd2,
		FN_DIV = 3'd3,
		FN_INV = 3'd4,
		FN_NEG = 3'd5
	} func_t;

	// control flags that travel with each transaction along the divider cells
	typedef struct packed {
		logic is_div;  // divider cells are active for this transaction
		logic dz;      // zero divisor seen
		logic ovf;     // saturation already seen (non-divide operations)
		logic neg_re;
		logic neg_im;
		logic big_re;  // real quotient at or above 2^WORD_BITS
		logic big_im;
	} ctl_t;

endpackage

@@ src/cau_if.sv @@
// cau_in_if, cau_out_if: valid/ready channels of the complex arithmetic unit
// depends on cau_pkg for the operation code width

interface cau_in_if #(parameter int WORD_BITS = 32);
	logic                             valid;
	logic                             ready;
	logic [cau_pkg::FUNC_BITS-1:0]    func;
	logic signed [WORD_BITS-1:0]      a_re;
	logic signed [WORD_BITS-1:0]      a_im;
	logic signed [WORD_BITS-1:0]      b_re;
	logic signed [WORD_BITS-1:0]      b_im;

	modport source(output valid, func, a_re, a_im, b_re, b_im, input ready);
	modport sink(input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(parameter int WORD_BITS = 32);
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] res_re;
	logic signed [WORD_BITS-1:0] res_im;
	logic                        div_zero;
	logic                        overflow;

	modport source(output valid, res_re, res_im, div_zero, overflow, input ready);
	modport sink(input valid, res_re, res_im, div_zero, overflow, output ready);
endinterface

@@ src/cau_cell.sv @@
// cau_cell: one restoring-division cell, one quotient bit per lane per transaction
// depends on cau_pkg (ctl_t)

module cau_cell #(
	parameter int WORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_i,
	input  cau_pkg::ctl_t            ctl_i,
	input  logic [2*WORD_BITS-1:0]   den_i,
	input  logic [2*WORD_BITS-1:0]   r_re_i,
	input  logic [2*WORD_BITS-1:0]   r_im_i,
	input  logic [WORD_BITS-1:0]     nq_re_i,
	input  logic [WORD_BITS-1:0]     nq_im_i,
	output logic                     v_o,
	output cau_pkg::ctl_t            ctl_o,
	output logic [2*WORD_BITS-1:0]   den_o,
	output logic [2*WORD_BITS-1:0]   r_re_o,
	output logic [2*WORD_BITS-1:0]   r_im_o,
	output logic [WORD_BITS-1:0]     nq_re_o,
	output logic [WORD_BITS-1:0]     nq_im_o
);

	localparam int W  = WORD_BITS;
	localparam int RW = 2 * W;

	logic [RW:0]   t_re, t_im, d_re, d_im, den_x;
	logic          ge_re, ge_im;
	logic [RW-1:0] r_re_n, r_im_n;
	logic [W-1:0]  nq_re_n, nq_im_n;

	always_comb begin
		den_x = {1'b0, den_i};
		// bring down the next numerator bit
		t_re  = {r_re_i, nq_re_i[W-1]};
		t_im  = {r_im_i, nq_im_i[W-1]};
		d_re  = t_re - den_x;
		d_im  = t_im - den_x;
		ge_re = t_re >= den_x;
		ge_im = t_im >= den_x;
		if (ctl_i.is_div) begin
			r_re_n  = ge_re ? d_re[RW-1:0] : t_re[RW-1:0];
			r_im_n  = ge_im ? d_im[RW-1:0] : t_im[RW-1:0];
			nq_re_n = {nq_re_i[W-2:0], ge_re};
			nq_im_n = {nq_im_i[W-2:0], ge_im};
		end else begin
			// finished result rides through untouched
			r_re_n  = r_re_i;
			r_im_n  = r_im_i;
			nq_re_n = nq_re_i;
			nq_im_n = nq_im_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_o   <= ctl_i;
			den_o   <= den_i;
			r_re_o  <= r_re_n;
			r_im_o  <= r_im_n;
			nq_re_o <= nq_re_n;
			nq_im_o <= nq_im_n;
		end
	end

endmodule

@@ src/cau_front.sv @@
// cau_front: operand capture, products, sums and divider set-up (four stages)
// depends on cau_pkg (func_t, ctl_t)

module cau_front #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_i,
	input  logic [cau_pkg::FUNC_BITS-1:0] func,
	input  logic signed [WORD_BITS-1:0]   a_re,
	input  logic signed [WORD_BITS-1:0]   a_im,
	input  logic signed [WORD_BITS-1:0]   b_re,
	input  logic signed [WORD_BITS-1:0]   b_im,
	output logic                          v_o,
	output cau_pkg::ctl_t                 ctl_o,
	output logic [2*WORD_BITS-1:0]        den_o,
	output logic [2*WORD_BITS-1:0]        r_re_o,
	output logic [2*WORD_BITS-1:0]        r_im_o,
	output logic [WORD_BITS-1:0]          nq_re_o,
	output logic [WORD_BITS-1:0]          nq_im_o
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int XW = W + 1;
	localparam int PW = 2 * XW;
	localparam int MW = 2 * W;
	localparam int NW = 2 * W + F;
	localparam int HW = W + F;
	localparam int CW = (HW > MW) ? HW : MW;

	localparam logic signed [PW:0] MAXV = {{(PW + 2 - W){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [PW:0] MINV = {{(PW + 2 - W){1'b1}}, {(W - 1){1'b0}}};
	localparam logic signed [PW:0] RND  = ((PW + 1)'(1) << F) - (PW + 1)'(1);

	// saturate to the word range: {overflow, value}
	function automatic logic [W:0] sat_w(input logic signed [PW:0] v);
		logic [W:0] r;
		if (v > MAXV) begin
			r = {1'b1, MAXV[W-1:0]};
		end else if (v < MINV) begin
			r = {1'b1, MINV[W-1:0]};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	// stage 1: operand capture
	logic                          v_s1;
	logic [cau_pkg::FUNC_BITS-1:0] func_s1;
	logic signed [W-1:0]           ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			ar_s1   <= a_re;
			ai_s1   <= a_im;
			br_s1   <= b_re;
			bi_s1   <= b_im;
		end
	end

	// stage 2: products and plain sums
	logic                 is_inv;
	logic signed [XW-1:0] xr, xi, yr, yi, s_re_c, s_im_c;
	logic signed [PW-1:0] p_rr_c, p_ii_c, p_ir_c, p_ri_c, d1_c, d2_c;

	always_comb begin
		is_inv = func_s1 == cau_pkg::FN_INV;
		xr = is_inv ? $signed((XW)'(1) << F) : XW'(ar_s1);
		xi = is_inv ? '0 : XW'(ai_s1);
		yr = is_inv ? XW'(ar_s1) : XW'(br_s1);
		yi = is_inv ? XW'(ai_s1) : XW'(bi_s1);
		p_rr_c = xr * yr;
		p_ii_c = xi * yi;
		p_ir_c = xi * yr;
		p_ri_c = xr * yi;
		d1_c   = yr * yr;
		d2_c   = yi * yi;
		case (func_s1)
			cau_pkg::FN_ADD: begin
				s_re_c = XW'(ar_s1) + XW'(br_s1);
				s_im_c = XW'(ai_s1) + XW'(bi_s1);
			end
			cau_pkg::FN_SUB: begin
				s_re_c = XW'(ar_s1) - XW'(br_s1);
				s_im_c = XW'(ai_s1) - XW'(bi_s1);
			end
			cau_pkg::FN_NEG: begin
				s_re_c = -XW'(ar_s1);
				s_im_c = -XW'(ai_s1);
			end
			default: begin
				s_re_c = '0;
				s_im_c = '0;
			end
		endcase
	end

	logic                          v_s2;
	logic [cau_pkg::FUNC_BITS-1:0] func_s2;
	logic signed [PW-1:0]          p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2, d1_s2, d2_s2;
	logic signed [XW-1:0]          s_re_s2, s_im_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			p_rr_s2 <= p_rr_c;
			p_ii_s2 <= p_ii_c;
			p_ir_s2 <= p_ir_c;
			p_ri_s2 <= p_ri_c;
			d1_s2   <= d1_c;
			d2_s2   <= d2_c;
			s_re_s2 <= s_re_c;
			s_im_s2 <= s_im_c;
		end
	end

	// stage 3: finish non-divide results, form divide magnitudes
	logic signed [PW:0] m_re, m_im, m_re_t, m_im_t, tr, ti;
	logic [PW:0]        dsum, tr_abs, ti_abs;
	logic [W:0]         sr_re, sr_im;
	logic [W-1:0]       res_re_c, res_im_c;
	logic               ovf_c;

	always_comb begin
		m_re   = (PW + 1)'(p_rr_s2) - (PW + 1)'(p_ii_s2);
		m_im   = (PW + 1)'(p_ri_s2) + (PW + 1)'(p_ir_s2);
		// shift toward zero
		m_re_t = (m_re[PW] ? m_re + RND : m_re) >>> F;
		m_im_t = (m_im[PW] ? m_im + RND : m_im) >>> F;
		tr     = (PW + 1)'(p_rr_s2) + (PW + 1)'(p_ii_s2);
		ti     = (PW + 1)'(p_ir_s2) - (PW + 1)'(p_ri_s2);
		tr_abs = tr[PW] ? -tr : tr;
		ti_abs = ti[PW] ? -ti : ti;
		dsum   = (PW + 1)'(d1_s2) + (PW + 1)'(d2_s2);
		case (func_s2)
			cau_pkg::FN_ADD, cau_pkg::FN_SUB, cau_pkg::FN_NEG: begin
				sr_re = sat_w((PW + 1)'(s_re_s2));
				sr_im = sat_w((PW + 1)'(s_im_s2));
			end
			cau_pkg::FN_MUL: begin
				sr_re = sat_w(m_re_t);
				sr_im = sat_w(m_im_t);
			end
			default: begin
				sr_re = '0;
				sr_im = '0;
			end
		endcase
		res_re_c = sr_re[W-1:0];
		res_im_c = sr_im[W-1:0];
		ovf_c    = sr_re[W] | sr_im[W];
	end

	logic                          v_s3;
	logic [cau_pkg::FUNC_BITS-1:0] func_s3;
	logic [W-1:0]                  res_re_s3, res_im_s3;
	logic                          ovf_s3, neg_re_s3, neg_im_s3;
	logic [MW-1:0]                 mag_re_s3, mag_im_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s3   <= func_s2;
			res_re_s3 <= res_re_c;
			res_im_s3 <= res_im_c;
			ovf_s3    <= ovf_c;
			neg_re_s3 <= tr[PW];
			neg_im_s3 <= ti[PW];
			mag_re_s3 <= tr_abs[MW-1:0];
			mag_im_s3 <= ti_abs[MW-1:0];
			den_s3    <= dsum[MW-1:0];
		end
	end

	// stage 4: quotient range check and first partial remainder
	logic [NW-1:0]  n_re, n_im;
	logic [CW-1:0]  hi_re, hi_im, den_c;
	logic           is_div, dz;
	cau_pkg::ctl_t  ctl_c;
	logic [MW-1:0]  r_re_c, r_im_c;
	logic [W-1:0]   nq_re_c, nq_im_c;

	always_comb begin
		n_re   = NW'(mag_re_s3) << F;
		n_im   = NW'(mag_im_s3) << F;
		hi_re  = CW'(n_re[NW-1:W]);
		hi_im  = CW'(n_im[NW-1:W]);
		den_c  = CW'(den_s3);
		is_div = (func_s3 == cau_pkg::FN_DIV) || (func_s3 == cau_pkg::FN_INV);
		dz     = den_s3 == '0;
		ctl_c.is_div = is_div & ~dz;
		ctl_c.dz     = is_div & dz;
		ctl_c.ovf    = ovf_s3;
		ctl_c.neg_re = neg_re_s3;
		ctl_c.neg_im = neg_im_s3;
		ctl_c.big_re = hi_re >= den_c;
		ctl_c.big_im = hi_im >= den_c;
		if (is_div) begin
			r_re_c  = ctl_c.big_re ? '0 : hi_re[MW-1:0];
			r_im_c  = ctl_c.big_im ? '0 : hi_im[MW-1:0];
			nq_re_c = n_re[W-1:0];
			nq_im_c = n_im[W-1:0];
		end else begin
			r_re_c  = '0;
			r_im_c  = '0;
			nq_re_c = res_re_s3;
			nq_im_c = res_im_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_o   <= ctl_c;
			den_o   <= den_s3;
			r_re_o  <= r_re_c;
			r_im_o  <= r_im_c;
			nq_re_o <= nq_re_c;
			nq_im_o <= nq_im_c;
		end
	end

endmodule

@@ src/complex_arith_unit.sv @@
// complex_arith_unit: pipelined complex ALU (add, sub, mul, div, inverse, negate)
// depends on cau_pkg, cau_if (channels), cau_front and cau_cell
//
//  channel | dir | transaction carries
//  --------+-----+------------------------------------------------
//  req     | in  | func, a_re, a_im, b_re, b_im
//  rsp     | out | res_re, res_im, div_zero, overflow
//
// one transaction accepted per clock while rsp is not stalled; each transaction
// passes four front stages, WORD_BITS division cells and one output register
// on its way from acceptance to rsp valid
// reset clears only the valid flags, so the pipe comes up empty at once
// a stalled rsp freezes the whole pipe and req.ready drops until it is taken

module complex_arith_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	cau_in_if.sink     req,
	cau_out_if.source  rsp
);

	localparam int W  = WORD_BITS;
	localparam int MW = 2 * W;

	// global advance: output register empty or being drained
	logic en;
	logic ov_q;

	assign en        = ~ov_q | rsp.ready;
	assign req.ready = en;

	// chain taps: index 0 is the front end, index W the last cell
	logic               v_c     [W+1];
	cau_pkg::ctl_t      ctl_c   [W+1];
	logic [MW-1:0]      den_c   [W+1];
	logic [MW-1:0]      r_re_c  [W+1];
	logic [MW-1:0]      r_im_c  [W+1];
	logic [W-1:0]       nq_re_c [W+1];
	logic [W-1:0]       nq_im_c [W+1];

	cau_front #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_i     (req.valid),
		.func    (req.func),
		.a_re    (req.a_re),
		.a_im    (req.a_im),
		.b_re    (req.b_re),
		.b_im    (req.b_im),
		.v_o     (v_c[0]),
		.ctl_o   (ctl_c[0]),
		.den_o   (den_c[0]),
		.r_re_o  (r_re_c[0]),
		.r_im_o  (r_im_c[0]),
		.nq_re_o (nq_re_c[0]),
		.nq_im_o (nq_im_c[0])
	);

	// one cell per quotient bit, most significant first
	for (genvar i = 0; i < W; i++) begin : g_cell
		cau_cell #(
			.WORD_BITS (WORD_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_i     (v_c[i]),
			.ctl_i   (ctl_c[i]),
			.den_i   (den_c[i]),
			.r_re_i  (r_re_c[i]),
			.r_im_i  (r_im_c[i]),
			.nq_re_i (nq_re_c[i]),
			.nq_im_i (nq_im_c[i]),
			.v_o     (v_c[i+1]),
			.ctl_o   (ctl_c[i+1]),
			.den_o   (den_c[i+1]),
			.r_re_o  (r_re_c[i+1]),
			.r_im_o  (r_im_c[i+1]),
			.nq_re_o (nq_re_c[i+1]),
			.nq_im_o (nq_im_c[i+1])
		);
	end

	// signed quotient with saturation: {overflow, value}
	function automatic logic [W:0] fix_q(input logic [W-1:0] q, input logic big,
			input logic neg);
		logic [W:0]   lim;
		logic [W-1:0] m;
		logic         o;
		lim = neg ? ((W + 1)'(1) << (W - 1)) : (((W + 1)'(1) << (W - 1)) - (W + 1)'(1));
		o   = big | ({1'b0, q} > lim);
		m   = o ? lim[W-1:0] : q;
		return {o, neg ? -m : m};
	endfunction

	cau_pkg::ctl_t ctl_l;
	logic [W:0]    fq_re, fq_im;
	logic [W-1:0]  res_re_d, res_im_d;
	logic          dz_d, ovf_d;

	always_comb begin
		ctl_l = ctl_c[W];
		fq_re = fix_q(nq_re_c[W], ctl_l.big_re, ctl_l.neg_re);
		fq_im = fix_q(nq_im_c[W], ctl_l.big_im, ctl_l.neg_im);
		if (ctl_l.dz) begin
			// zero divisor: zero result, no saturation
			res_re_d = '0;
			res_im_d = '0;
			dz_d     = 1'b1;
			ovf_d    = 1'b0;
		end else if (ctl_l.is_div) begin
			res_re_d = fq_re[W-1:0];
			res_im_d = fq_im[W-1:0];
			dz_d     = 1'b0;
			ovf_d    = fq_re[W] | fq_im[W];
		end else begin
			res_re_d = nq_re_c[W];
			res_im_d = nq_im_c[W];
			dz_d     = 1'b0;
			ovf_d    = ctl_l.ovf;
		end
	end

	// output register
	logic [W-1:0] res_re_q, res_im_q;
	logic         dz_q, ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= v_c[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= res_re_d;
			res_im_q <= res_im_d;
			dz_q     <= dz_d;
			ovf_q    <= ovf_d;
		end
	end

	assign rsp.valid    = ov_q;
	assign rsp.res_re   = res_re_q;
	assign rsp.res_im   = res_im_q;
	assign rsp.div_zero = dz_q;
	assign rsp.overflow = ovf_q;

	// a zero divisor always gives a clean zero result
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.div_zero |-> rsp.res_re == '0 && rsp.res_im == '0 && !rsp.overflow)
		else $error("div_zero result not zero");

	// a waiting result stalls the input side
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("input accepted while output stalled");

	// a waiting result is neither lost nor altered
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.res_re) && $stable(rsp.res_im))
		else $error("stalled result changed");

	// the end of the chain reaches the output register on every advance
	a_chain_load: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_c[W] |=> rsp.valid)
		else $error("chain output dropped");

endmodule
